// ----- rtl/assert_macros.svh -----
// Assertion helpers; every user has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/rpr_pkg.sv -----
package rpr_pkg;

	localparam int PIX_W     = 24;
	localparam int CAM_W     = 40;
	localparam int ROT_W     = 31;
	localparam int DIV_W     = 62;
	localparam int DEN_W     = 39;
	localparam int DIV_STEPS = DIV_W;

	localparam logic [1:0] REG_FOCAL_X  = 2'd0;
	localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
	localparam logic [1:0] REG_CENTER_X = 2'd2;
	localparam logic [1:0] REG_CENTER_Y = 2'd3;

	localparam logic [PIX_W-1:0] FOCAL_X_RST  = 24'd134400;
	localparam logic [PIX_W-1:0] FOCAL_Y_RST  = 24'd134400;
	localparam logic [PIX_W-1:0] CENTER_X_RST = 24'd81792;
	localparam logic [PIX_W-1:0] CENTER_Y_RST = 24'd61312;

	localparam logic signed [31:0] RES_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] RES_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [PIX_W-1:0]   obs_u;
		logic [PIX_W-1:0]   obs_v;
	} item_t;

	typedef struct packed {
		logic signed [CAM_W-1:0] cam_x;
		logic signed [CAM_W-1:0] cam_y;
		logic signed [CAM_W-1:0] cam_z;
		logic                    behind;
		logic [PIX_W-1:0]        obs_u;
		logic [PIX_W-1:0]        obs_v;
	} cam_t;

	typedef struct packed {
		logic [PIX_W-1:0] obs_u;
		logic [PIX_W-1:0] obs_v;
		logic             behind;
		logic             neg_u;
		logic             neg_v;
	} div_side_t;

	typedef struct packed {
		logic [DIV_W-1:0] dvd_u;
		logic [DIV_W-1:0] dvd_v;
		logic [DEN_W-1:0] den;
		div_side_t        side;
	} div_in_t;

	typedef struct packed {
		logic [DIV_W-1:0] quot_u;
		logic [DIV_W-1:0] quot_v;
		div_side_t        side;
	} div_out_t;

endpackage

// ----- rtl/rpr_camera.sv -----
module rpr_camera import rpr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  item_t in_item,
	output logic  out_vld,
	output cam_t  out_cam
);

	localparam logic signed [34:0] ONE28 = 35'sd268435456;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	item_t item_s1, item_s2, item_s3, item_s4;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [ROT_W-1:0] r_s2 [9];
	logic signed [62:0] prod_s3 [9];
	logic signed [63:0] acc_s4 [3];
	cam_t cam_s5;

	logic signed [34:0] rf [9];
	logic signed [34:0] rr [9];
	logic signed [ROT_W-1:0] r_n [9];
	logic signed [31:0] pt [3];
	logic signed [31:0] tr [3];
	logic signed [63:0] cr [3];
	logic signed [CAM_W-1:0] c_n [3];

	// matrix entries in Q.28, then round to Q.24 with ties away from zero
	always_comb begin
		rf[0] = ONE28 - ((35'(yy_s1) + 35'(zz_s1)) <<< 1);
		rf[1] = (35'(xy_s1) - 35'(wz_s1)) <<< 1;
		rf[2] = (35'(wy_s1) + 35'(xz_s1)) <<< 1;
		rf[3] = (35'(xy_s1) + 35'(wz_s1)) <<< 1;
		rf[4] = ONE28 - ((35'(xx_s1) + 35'(zz_s1)) <<< 1);
		rf[5] = (35'(yz_s1) - 35'(wx_s1)) <<< 1;
		rf[6] = (35'(xz_s1) - 35'(wy_s1)) <<< 1;
		rf[7] = (35'(wx_s1) + 35'(yz_s1)) <<< 1;
		rf[8] = ONE28 - ((35'(xx_s1) + 35'(yy_s1)) <<< 1);
		for (int k = 0; k < 9; k++) begin
			rr[k]  = rf[k] + 35'sd8 - $signed({34'd0, rf[k][34]});
			r_n[k] = ROT_W'(rr[k] >>> 4);
		end
	end

	always_comb begin
		pt[0] = item_s2.point_x;
		pt[1] = item_s2.point_y;
		pt[2] = item_s2.point_z;
		tr[0] = item_s3.trans_x;
		tr[1] = item_s3.trans_y;
		tr[2] = item_s3.trans_z;
		for (int i = 0; i < 3; i++) begin
			cr[i]  = acc_s4[i] + 64'sd8388608 - $signed({63'd0, acc_s4[i][63]});
			c_n[i] = CAM_W'(cr[i] >>> 24);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		xx_s1   <= in_item.quat_x * in_item.quat_x;
		yy_s1   <= in_item.quat_y * in_item.quat_y;
		zz_s1   <= in_item.quat_z * in_item.quat_z;
		xy_s1   <= in_item.quat_x * in_item.quat_y;
		xz_s1   <= in_item.quat_x * in_item.quat_z;
		yz_s1   <= in_item.quat_y * in_item.quat_z;
		wx_s1   <= in_item.quat_w * in_item.quat_x;
		wy_s1   <= in_item.quat_w * in_item.quat_y;
		wz_s1   <= in_item.quat_w * in_item.quat_z;
		item_s1 <= in_item;
		r_s2    <= r_n;
		item_s2 <= item_s1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s3[3*i+j] <= r_s2[3*i+j] * pt[j];
			end
		end
		item_s3 <= item_s2;
		for (int i = 0; i < 3; i++) begin
			acc_s4[i] <= 64'(prod_s3[3*i]) + 64'(prod_s3[3*i+1]) + 64'(prod_s3[3*i+2])
				+ (64'(tr[i]) <<< 24);
		end
		item_s4 <= item_s3;
		cam_s5.cam_x  <= c_n[0];
		cam_s5.cam_y  <= c_n[1];
		cam_s5.cam_z  <= c_n[2];
		cam_s5.behind <= c_n[2][CAM_W-1] || (c_n[2] == '0);
		cam_s5.obs_u  <= item_s4.obs_u;
		cam_s5.obs_v  <= item_s4.obs_v;
	end

	assign out_vld = vld_s5;
	assign out_cam = cam_s5;

endmodule

// ----- rtl/rpr_scale.sv -----
module rpr_scale import rpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  cam_t             in_cam,
	input  logic [PIX_W-1:0] focal_x,
	input  logic [PIX_W-1:0] focal_y,
	output logic             out_vld,
	output div_in_t          out_div
);

	logic vld_s6, vld_s7, vld_s8;
	logic [43:0] plo_u_s6, plo_v_s6;
	logic signed [44:0] phi_u_s6, phi_v_s6;
	logic [DEN_W-1:0] den_s6, den_s7;
	div_side_t side_s6, side_s7;
	logic signed [63:0] num_u_s7, num_v_s7;
	div_in_t div_s8;

	logic [63:0] mag_u, mag_v;

	// magnitude of the numerator; half the divisor is added for rounding
	always_comb begin
		mag_u = num_u_s7[63] ? 64'(-num_u_s7) : 64'(num_u_s7);
		mag_v = num_v_s7[63] ? 64'(-num_v_s7) : 64'(num_v_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s6 <= in_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		plo_u_s6 <= focal_x * in_cam.cam_x[19:0];
		plo_v_s6 <= focal_y * in_cam.cam_y[19:0];
		phi_u_s6 <= $signed({1'b0, focal_x}) * $signed(in_cam.cam_x[CAM_W-1:20]);
		phi_v_s6 <= $signed({1'b0, focal_y}) * $signed(in_cam.cam_y[CAM_W-1:20]);
		// keep the divisor positive when the point is behind the camera
		den_s6   <= in_cam.behind ? DEN_W'(1) : in_cam.cam_z[DEN_W-1:0];
		side_s6.obs_u  <= in_cam.obs_u;
		side_s6.obs_v  <= in_cam.obs_v;
		side_s6.behind <= in_cam.behind;
		side_s6.neg_u  <= 1'b0;
		side_s6.neg_v  <= 1'b0;

		num_u_s7 <= (64'(phi_u_s6) <<< 20) + $signed({20'd0, plo_u_s6});
		num_v_s7 <= (64'(phi_v_s6) <<< 20) + $signed({20'd0, plo_v_s6});
		den_s7   <= den_s6;
		side_s7  <= side_s6;

		div_s8.dvd_u       <= mag_u[DIV_W-1:0] + {24'd0, den_s7[DEN_W-1:1]};
		div_s8.dvd_v       <= mag_v[DIV_W-1:0] + {24'd0, den_s7[DEN_W-1:1]};
		div_s8.den         <= den_s7;
		div_s8.side.obs_u  <= side_s7.obs_u;
		div_s8.side.obs_v  <= side_s7.obs_v;
		div_s8.side.behind <= side_s7.behind;
		div_s8.side.neg_u  <= num_u_s7[63];
		div_s8.side.neg_v  <= num_v_s7[63];
	end

	assign out_vld = vld_s8;
	assign out_div = div_s8;

endmodule

// ----- rtl/rpr_divider.sv -----
`include "assert_macros.svh"

module rpr_divider import rpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_vld,
	input  div_in_t  in_div,
	output logic     out_vld,
	output div_out_t out_quot
);

	typedef struct packed {
		logic [DIV_W-1:0] dq_u;
		logic [DIV_W-1:0] dq_v;
		logic [DEN_W-1:0] rem_u;
		logic [DEN_W-1:0] rem_v;
		logic [DEN_W-1:0] den;
		div_side_t        side;
	} stage_t;

	stage_t stg_in;
	stage_t stg_s [DIV_STEPS];
	logic [DIV_STEPS-1:0] vld_s;

	// one restoring step: shift in a dividend bit, subtract if it fits
	function automatic logic [DEN_W+DIV_W-1:0] div_bit(input logic [DIV_W-1:0] dq,
			input logic [DEN_W-1:0] rem, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		trial = {rem, dq[DIV_W-1]};
		diff  = trial - {1'b0, den};
		if (trial >= {1'b0, den})
			return {diff[DEN_W-1:0], dq[DIV_W-2:0], 1'b1};
		return {trial[DEN_W-1:0], dq[DIV_W-2:0], 1'b0};
	endfunction

	function automatic stage_t advance(input stage_t s);
		stage_t n;
		n = s;
		{n.rem_u, n.dq_u} = div_bit(s.dq_u, s.rem_u, s.den);
		{n.rem_v, n.dq_v} = div_bit(s.dq_v, s.rem_v, s.den);
		return n;
	endfunction

	always_comb begin
		stg_in.dq_u  = in_div.dvd_u;
		stg_in.dq_v  = in_div.dvd_v;
		stg_in.rem_u = '0;
		stg_in.rem_v = '0;
		stg_in.den   = in_div.den;
		stg_in.side  = in_div.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else
			vld_s <= {vld_s[DIV_STEPS-2:0], in_vld};
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= advance(stg_in);
		for (int k = 1; k < DIV_STEPS; k++) begin
			stg_s[k] <= advance(stg_s[k-1]);
		end
	end

	assign out_vld         = vld_s[DIV_STEPS-1];
	assign out_quot.quot_u = stg_s[DIV_STEPS-1].dq_u;
	assign out_quot.quot_v = stg_s[DIV_STEPS-1].dq_v;
	assign out_quot.side   = stg_s[DIV_STEPS-1].side;

	`RPR_ASSERT_IMP(a_rem_below_den, vld_s[DIV_STEPS-1], (stg_s[DIV_STEPS-1].rem_u < stg_s[DIV_STEPS-1].den) && (stg_s[DIV_STEPS-1].rem_v < stg_s[DIV_STEPS-1].den), "divider remainder not below divisor")

endmodule

// ----- rtl/pinhole_reprojection_residual.sv -----
// One word per clock; start may be high every cycle, and busy is always low.
// The 62-step restoring divider (one quotient bit per stage) sets most of the latency.
// The receiver cannot stall, so the pipeline never holds; done is high for one cycle per word.
// Reset clears all valid bits and loads the default intrinsics (525.0, 319.5, 239.5).
`include "assert_macros.svh"

module pinhole_reprojection_residual import rpr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [PIX_W-1:0]   cfg_wdata,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic [PIX_W-1:0]   obs_u,
	input  logic [PIX_W-1:0]   obs_v,
	output logic               done,
	output logic signed [31:0] res_u,
	output logic signed [31:0] res_v,
	output logic               behind_camera,
	output logic               clipped
);

	logic [PIX_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

	item_t    item;
	logic     cam_vld, div_in_vld, quot_vld;
	cam_t     cam;
	div_in_t  div_in;
	div_out_t quot;

	logic vld_s71, vld_s72;
	logic signed [63:0] sq_u_s71, sq_v_s71;
	logic signed [25:0] cmo_u_s71, cmo_v_s71;
	logic behind_s71;
	logic signed [31:0] res_u_s72, res_v_s72;
	logic behind_s72, clip_s72;

	logic signed [63:0] q_u, q_v, sum_u, sum_v;
	logic ovf_u, ovf_v;

	// the block never refuses a word
	assign busy = 1'b0;

	// intrinsics: the user must write them only while the pipeline is empty; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FOCAL_X:  focal_x_q  <= cfg_wdata;
				REG_FOCAL_Y:  focal_y_q  <= cfg_wdata;
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
			endcase
		end
	end

	always_comb begin
		item.quat_w  = quat_w;
		item.quat_x  = quat_x;
		item.quat_y  = quat_y;
		item.quat_z  = quat_z;
		item.trans_x = trans_x;
		item.trans_y = trans_y;
		item.trans_z = trans_z;
		item.point_x = point_x;
		item.point_y = point_y;
		item.point_z = point_z;
		item.obs_u   = obs_u;
		item.obs_v   = obs_v;
	end

	// stages 1-5: rotate, translate and round to camera coordinates
	rpr_camera u_camera (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.in_item (item),
		.out_vld (cam_vld),
		.out_cam (cam)
	);

	// stages 6-8: focal products and rounding bias for the divider
	rpr_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cam_vld),
		.in_cam  (cam),
		.focal_x (focal_x_q),
		.focal_y (focal_y_q),
		.out_vld (div_in_vld),
		.out_div (div_in)
	);

	// stages 9-70: both axes share the depth as divisor
	rpr_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (div_in_vld),
		.in_div   (div_in),
		.out_vld  (quot_vld),
		.out_quot (quot)
	);

	// restore the sign of the quotient; fold principal point and observation
	always_comb begin
		q_u = $signed({2'd0, quot.quot_u});
		q_v = $signed({2'd0, quot.quot_v});
	end

	// add and saturate to the 32-bit residual range
	always_comb begin
		sum_u = sq_u_s71 + 64'(cmo_u_s71);
		sum_v = sq_v_s71 + 64'(cmo_v_s71);
		ovf_u = !((sum_u[63:31] == '0) || (sum_u[63:31] == '1));
		ovf_v = !((sum_v[63:31] == '0) || (sum_v[63:31] == '1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s71 <= 1'b0;
			vld_s72 <= 1'b0;
		end else begin
			vld_s71 <= quot_vld;
			vld_s72 <= vld_s71;
		end
	end

	always_ff @(posedge clk) begin
		sq_u_s71   <= quot.side.neg_u ? -q_u : q_u;
		sq_v_s71   <= quot.side.neg_v ? -q_v : q_v;
		cmo_u_s71  <= $signed({2'd0, center_x_q}) - $signed({2'd0, quot.side.obs_u});
		cmo_v_s71  <= $signed({2'd0, center_y_q}) - $signed({2'd0, quot.side.obs_v});
		behind_s71 <= quot.side.behind;

		behind_s72 <= behind_s71;
		if (behind_s71) begin
			// drop the projection: zero residuals, no clip
			res_u_s72 <= '0;
			res_v_s72 <= '0;
			clip_s72  <= 1'b0;
		end else begin
			res_u_s72 <= ovf_u ? (sum_u[63] ? RES_MIN : RES_MAX) : sum_u[31:0];
			res_v_s72 <= ovf_v ? (sum_v[63] ? RES_MIN : RES_MAX) : sum_v[31:0];
			clip_s72  <= ovf_u || ovf_v;
		end
	end

	assign done          = vld_s72;
	assign res_u         = res_u_s72;
	assign res_v         = res_v_s72;
	assign behind_camera = behind_s72;
	assign clipped       = clip_s72;

	`RPR_ASSERT_IMP(a_behind_zero, done && behind_camera, (res_u == '0) && (res_v == '0) && !clipped, "behind-camera word carries nonzero residual")
	`RPR_ASSERT_IMP(a_clip_at_limit, done && clipped, (res_u == RES_MAX) || (res_u == RES_MIN) || (res_v == RES_MAX) || (res_v == RES_MIN), "clipped word has no residual at a limit")
	`RPR_ASSERT(a_done_follows_valid, done == $past(quot_vld, 2), "done out of step with divider output")

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import rpr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// Leave margin for the pipeline to drain before touching the intrinsics.
	localparam int DRAIN_CYCLES = 90;

	typedef struct packed {
		logic signed [31:0] res_u;
		logic signed [31:0] res_v;
		logic               behind;
		logic               clip;
	} residual_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = REG_FOCAL_X;
	logic [PIX_W-1:0] cfg_wdata = '0;
	item_t drv = '0;
	logic done;
	logic signed [31:0] res_u;
	logic signed [31:0] res_v;
	logic behind_camera;
	logic clipped;

	// Mirror of the intrinsics the block should hold.
	logic [PIX_W-1:0] focal_x_m = FOCAL_X_RST;
	logic [PIX_W-1:0] focal_y_m = FOCAL_Y_RST;
	logic [PIX_W-1:0] center_x_m = CENTER_X_RST;
	logic [PIX_W-1:0] center_y_m = CENTER_Y_RST;

	item_t pending_words[$];
	residual_t expected_res[$];
	int mismatches = 0;
	int gap_left = 0;
	bit no_idle = 1'b0;
	int cycles = 0;

	always #5 clk = ~clk;

	pinhole_reprojection_residual uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.quat_w(drv.quat_w), .quat_x(drv.quat_x), .quat_y(drv.quat_y),
		.quat_z(drv.quat_z), .trans_x(drv.trans_x), .trans_y(drv.trans_y),
		.trans_z(drv.trans_z), .point_x(drv.point_x), .point_y(drv.point_y),
		.point_z(drv.point_z), .obs_u(drv.obs_u), .obs_v(drv.obs_v),
		.done(done), .res_u(res_u), .res_v(res_v),
		.behind_camera(behind_camera), .clipped(clipped)
	);

	// Round to nearest, ties away from zero, by a right shift.
	function automatic longint shift_round(longint v, int s);
		longint unsigned mag;
		mag = (v < 0) ? longint'(-v) : v;
		mag = (mag + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// Rounded quotient; the depth is positive whenever this is reached.
	function automatic longint div_round(longint num, longint den);
		longint unsigned mag, d;
		mag = (num < 0) ? longint'(-num) : num;
		d = den;
		mag = (mag + d / 2) / d;
		return (num < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp32(longint v, ref bit clip);
		if (v > 64'sd2147483647) begin
			clip = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			clip = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Rotate, translate and project one observation; give its pixel residuals.
	function automatic residual_t reproject(item_t it);
		longint w, x, y, z;
		longint rot[9];
		longint pt[3];
		longint tr[3];
		longint cam[3];
		longint ru, rv;
		bit clip;
		residual_t r;
		w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
		pt[0] = it.point_x; pt[1] = it.point_y; pt[2] = it.point_z;
		tr[0] = it.trans_x; tr[1] = it.trans_y; tr[2] = it.trans_z;
		clip = 1'b0;
		rot[0] = (64'sd1 << 28) - 2 * (y * y + z * z);
		rot[1] = 2 * (x * y - w * z);
		rot[2] = 2 * (w * y + x * z);
		rot[3] = 2 * (x * y + w * z);
		rot[4] = (64'sd1 << 28) - 2 * (x * x + z * z);
		rot[5] = 2 * (y * z - w * x);
		rot[6] = 2 * (x * z - w * y);
		rot[7] = 2 * (w * x + y * z);
		rot[8] = (64'sd1 << 28) - 2 * (x * x + y * y);
		for (int i = 0; i < 9; i++)
			rot[i] = shift_round(rot[i], 4);
		for (int i = 0; i < 3; i++)
			cam[i] = shift_round(rot[3*i] * pt[0] + rot[3*i+1] * pt[1]
				+ rot[3*i+2] * pt[2] + tr[i] * (64'sd1 << 24), 24);
		r = '0;
		if (cam[2] <= 0) begin
			r.behind = 1'b1;
			return r;
		end
		ru = div_round(longint'(focal_x_m) * cam[0], cam[2])
			+ longint'(center_x_m) - longint'(it.obs_u);
		rv = div_round(longint'(focal_y_m) * cam[1], cam[2])
			+ longint'(center_y_m) - longint'(it.obs_v);
		r.res_u = 32'(clamp32(ru, clip));
		r.res_v = 32'(clamp32(rv, clip));
		r.clip = clip;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Append a word to the driver's queue.
	task automatic queue_word(item_t it);
		pending_words.insert(pending_words.size(), it);
	endtask

	// Driver: hold a word until start && !busy takes it, then idle a drawn gap.
	always @(posedge clk) begin
		item_t taken;
		bit go;
		go = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				taken = pending_words.pop_front();
				expected_res.insert(expected_res.size(), reproject(taken));
				gap_left = no_idle ? 0 : $urandom_range(0, 14);
			end
			if (gap_left > 0)
				gap_left--;
			else if (pending_words.size() > 0) begin
				go = 1'b1;
				drv <= pending_words[0];
			end
		end
		start <= go;
	end

	// Monitor: compare each done word with the oldest prediction.
	always @(posedge clk) begin
		residual_t want;
		if (arst_n && done) begin
			if (expected_res.size() == 0)
				report("unexpected result", res_u, '0);
			else begin
				want = expected_res.pop_front();
				if (res_u !== want.res_u) report("res_u", res_u, want.res_u);
				if (res_v !== want.res_v) report("res_v", res_v, want.res_v);
				if (behind_camera !== want.behind)
					report("behind_camera", 32'(behind_camera), 32'(want.behind));
				if (clipped !== want.clip)
					report("clipped", 32'(clipped), 32'(want.clip));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [PIX_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_FOCAL_X:  focal_x_m = val;
			REG_FOCAL_Y:  focal_y_m = val;
			REG_CENTER_X: center_x_m = val;
			default:      center_y_m = val;
		endcase
	endtask

	task automatic set_intrinsics(logic [PIX_W-1:0] fx, logic [PIX_W-1:0] fy,
			logic [PIX_W-1:0] cx, logic [PIX_W-1:0] cy);
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
	endtask

	// Block until every word is in and out, then let the pipeline drain.
	task automatic drain();
		while (pending_words.size() > 0 || expected_res.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic item_t make_word(logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] tz,
			logic [PIX_W-1:0] ou, logic [PIX_W-1:0] ov);
		item_t it;
		it = '0;
		it.quat_w = qw; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz;
		it.point_x = px; it.point_y = py; it.point_z = pz; it.trans_z = tz;
		it.obs_u = ou; it.obs_v = ov;
		return it;
	endfunction

	// Mostly sane poses looking at points in front; the rest is wide or raw noise.
	function automatic item_t random_word();
		item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		{it.quat_w, it.quat_x, it.quat_y, it.quat_z} = {$urandom, $urandom};
		{it.trans_x, it.trans_y, it.trans_z} = {$urandom, $urandom, $urandom};
		{it.point_x, it.point_y, it.point_z} = {$urandom, $urandom, $urandom};
		{it.obs_u, it.obs_v} = 48'({$urandom, $urandom});
		if (sel < 65) begin
			it.quat_w = 16'(16384 - $urandom_range(0, 3000));
			it.quat_x = 16'($signed($urandom_range(0, 8000)) - 4000);
			it.quat_y = 16'($signed($urandom_range(0, 8000)) - 4000);
			it.quat_z = 16'($signed($urandom_range(0, 8000)) - 4000);
			it.trans_x = $signed($urandom_range(0, 262144)) - 131072;
			it.trans_y = $signed($urandom_range(0, 262144)) - 131072;
			it.trans_z = $signed($urandom_range(0, 131072)) - 65536;
			it.point_x = $signed($urandom_range(0, 1310720)) - 655360;
			it.point_y = $signed($urandom_range(0, 1310720)) - 655360;
			it.point_z = $urandom_range(32768, 3276800);
			it.obs_u = 24'($urandom_range(0, 163840));
			it.obs_v = 24'($urandom_range(0, 122880));
		end else if (sel < 85) begin
			it.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
			it.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
			it.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
			it.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
			it.point_z = $signed($urandom_range(0, 6553600)) - 1638400;
		end
		return it;
	endfunction

	initial begin
		logic [PIX_W-1:0] fx[5] = '{24'd134400, 24'd0, 24'hFFFFFF, 24'd51200, 24'd300000};
		logic [PIX_W-1:0] cy[5] = '{24'd0, 24'hFFFFFF, 24'd0, 24'd61312, 24'd100};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset intrinsics.
		no_idle = 1'b1;
		// identity pose, point on the axis: residual is center minus observation
		queue_word(make_word(16384, 0, 0, 0, 0, 0, 65536, 0, 0, 0));
		queue_word(make_word(16384, 0, 0, 0, 65536, -65536, 131072, 0,
			24'hFFFFFF, 24'hFFFFFF));
		// depth exactly zero, and depth negative
		queue_word(make_word(16384, 0, 0, 0, 65536, 0, 0, 0, 0, 0));
		queue_word(make_word(16384, 0, 0, 0, 0, 0, -65536, 0, 0, 0));
		// depth pulled negative by translation only
		queue_word(make_word(16384, 0, 0, 0, 0, 0, 65536, -131072, 0, 0));
		// tiny depth with a far lateral point: both residuals saturate
		queue_word(make_word(16384, 0, 0, 0, 32'sh7fffffff,
			32'sh80000000, 1, 0, 0, 0));
		queue_word(make_word(16384, 0, 0, 0, 32'sh80000000,
			32'sh7fffffff, 1, 0, 24'hFFFFFF, 0));
		// half-turn about x flips depth sign
		queue_word(make_word(0, 16384, 0, 0, 0, 0, -65536, 0, 100, 200));
		// quaternion extremes, far from unit length
		queue_word(make_word(-32768, -32768, -32768, -32768,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
		queue_word(make_word(32767, 32767, 32767, 32767,
			32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 24'hFFFFFF, 0));
		queue_word(make_word(0, 0, 0, 0, 100, 200, 300, 65536, 5, 5));
		queue_word(make_word(-16384, 0, 0, 0, 1000, -1000, 65536, 0, 0, 0));
		for (int i = 0; i < 8; i++)
			queue_word(random_word());
		drain();

		// Random phases, each under its own intrinsics, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			set_intrinsics(fx[ph], fx[4 - ph], cy[4 - ph], cy[ph]);
			no_idle = (ph == 2);
			for (int i = 0; i < 168; i++)
				queue_word(random_word());
			drain();
		end

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
